// File: src/sorted_symbol_floor_table_assert.svh
`ifndef SORTED_SYMBOL_FLOOR_TABLE_ASSERT_SVH
`define SORTED_SYMBOL_FLOOR_TABLE_ASSERT_SVH

// same-cycle implication
`define SSFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ssft_pkg.sv
package ssft_pkg;

    localparam int DEPTH    = 64;
    localparam int TAG_BITS = 16;

    localparam int ADDR_W   = 32;
    localparam int TAG_W    = 16;
    localparam int POS_W    = 7;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int PCMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_DATA_W  = ((ADDR_W + TAG_W + POS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ADDR_W + TAG_W + ADDR_W + 7) / 8) * 8;

    localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((64'd1 << TAG_BITS) - 64'd1);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FLOOR  = 2'd1,
        OP_EXACT  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_FIN
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] key;
        logic [TAG_W-1:0]  tag;
        logic [POS_W-1:0]  position;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] address;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] offset;
    } res_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TAG_W-1:0]  tag;
    } entry_t;

endpackage

// File: src/ssft_core.sv
`include "sorted_symbol_floor_table_assert.svh"

module ssft_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ssft_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output ssft_pkg::res_t res
);
    import ssft_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    op_t               op_reg, op_next;
    logic [ADDR_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] cand_addr_reg, cand_addr_next;
    logic [TAG_W-1:0]  cand_tag_reg, cand_tag_next;

    entry_t            mem [DEPTH];
    entry_t            rd_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    entry_t            mem_wdata;

    logic [PCMP_W-1:0] pos_ext;
    logic [PCMP_W-1:0] cnt_ext;
    logic [CNT_W-1:0]  idx_dec;
    logic              at_end;
    entry_t            new_entry;

    assign pos_ext   = PCMP_W'(req.position);
    assign cnt_ext   = PCMP_W'(count_reg);
    assign idx_dec   = idx_reg - 1'b1;
    assign at_end    = (idx_reg == count_reg);
    assign new_entry = '{addr: key_reg, tag: tag_reg};

    // entry store, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            op_reg    <= OP_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        tag_reg       <= tag_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        cand_addr_reg <= cand_addr_next;
        cand_tag_reg  <= cand_tag_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                unique case (op_reg)
                    OP_INSERT: state_next = (!found_reg || idx_reg == '0) ? S_FIN : S_CMP;
                    OP_FLOOR,
                    OP_EXACT:  state_next = at_end ? S_FIN : S_CMP;
                    OP_READ:   state_next = found_reg ? S_CMP : S_FIN;
                endcase
            end
            S_CMP:
            begin
                unique case (op_reg)
                    OP_INSERT: state_next = (rd_reg.addr > key_reg) ? S_RD : S_FIN;
                    OP_FLOOR:  state_next = (rd_reg.addr <= key_reg) ? S_RD : S_FIN;
                    OP_EXACT:  state_next = (rd_reg.addr < key_reg) ? S_RD : S_FIN;
                    OP_READ:   state_next = S_FIN;
                endcase
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        tag_next       = tag_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        cand_addr_next = cand_addr_reg;
        cand_tag_next  = cand_tag_reg;
        count_next     = count_reg;
        mem_we         = 1'b0;
        mem_waddr      = IDX_W'(idx_reg);
        mem_wdata      = rd_reg;
        mem_raddr      = IDX_W'(idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next        = req.op;
                    key_next       = req.key;
                    tag_next       = req.tag & TAG_MASK;
                    idx_next       = '0;
                    found_next     = 1'b0;
                    cand_addr_next = '0;
                    cand_tag_next  = '0;
                    unique case (req.op)
                        OP_INSERT:
                        begin
                            idx_next   = count_reg;
                            found_next = (count_reg < CNT_W'(DEPTH));
                        end
                        OP_READ:
                        begin
                            idx_next   = CNT_W'(pos_ext);
                            found_next = (pos_ext < cnt_ext);
                        end
                        OP_FLOOR,
                        OP_EXACT:
                        begin
                            idx_next = '0;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                if (op_reg == OP_INSERT)
                begin
                    mem_raddr = IDX_W'(idx_dec);
                    if (found_reg && idx_reg == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = new_entry;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            S_CMP:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        mem_we = 1'b1;
                        if (rd_reg.addr > key_reg)
                        begin
                            mem_wdata = rd_reg;
                            idx_next  = idx_dec;
                        end
                        else
                        begin
                            mem_wdata  = new_entry;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    OP_FLOOR:
                    begin
                        if (rd_reg.addr <= key_reg)
                        begin
                            idx_next = idx_reg + 1'b1;
                            // first of a run of equal addresses
                            if (!found_reg || rd_reg.addr != cand_addr_reg)
                            begin
                                found_next     = 1'b1;
                                cand_addr_next = rd_reg.addr;
                                cand_tag_next  = rd_reg.tag;
                            end
                        end
                    end
                    OP_EXACT:
                    begin
                        if (rd_reg.addr < key_reg)
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                        else
                        begin
                            found_next    = (rd_reg.addr == key_reg);
                            cand_tag_next = rd_reg.tag;
                        end
                    end
                    OP_READ:
                    begin
                        cand_addr_next = rd_reg.addr;
                        cand_tag_next  = rd_reg.tag;
                    end
                endcase
            end
            S_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // result
    always_comb
    begin
        req_ready = (state_reg == S_IDLE);
        res_valid = (state_reg == S_FIN);
        res       = '{status: ST_MISS, address: key_reg, tag: '0, offset: '0};
        unique case (op_reg)
            OP_INSERT:
            begin
                res.status = found_reg ? ST_OK : ST_FULL;
                res.tag    = found_reg ? tag_reg : '0;
            end
            OP_FLOOR:
            begin
                if (found_reg)
                begin
                    res.status  = ST_OK;
                    res.address = cand_addr_reg;
                    res.tag     = cand_tag_reg;
                    res.offset  = key_reg - cand_addr_reg;
                end
            end
            OP_EXACT:
            begin
                if (found_reg)
                begin
                    res.status = ST_OK;
                    res.tag    = cand_tag_reg;
                end
            end
            OP_READ:
            begin
                res.address = found_reg ? cand_addr_reg : '0;
                res.status  = found_reg ? ST_OK : ST_MISS;
                res.tag     = found_reg ? cand_tag_reg : '0;
            end
        endcase
    end

    `SSFT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH),
        "entry count beyond capacity")
    `SSFT_ASSERT_NOW(a_write_insert_only, clk, rst_n, mem_we,
        op_reg == OP_INSERT && (state_reg == S_RD || state_reg == S_CMP),
        "store written outside an insert")
    `SSFT_ASSERT_NEXT(a_count_lookup_stable, clk, rst_n,
        state_reg != S_IDLE && op_reg != OP_INSERT, $stable(count_reg),
        "entry count changed by a lookup")
    `SSFT_ASSERT_NEXT(a_result_held, clk, rst_n, state_reg == S_FIN && !res_ready,
        state_reg == S_FIN && $stable(res), "pending result not held")

endmodule

// File: src/sorted_symbol_floor_table.sv
// Sorted symbol table with floor, exact and positional lookup.
// Input words arrive on s_axis; the opcode rides in tuser (insert, floor,
// exact, read position). Each input word yields exactly one result word on
// m_axis with the status in tuser.
// One word is worked on at a time: s_axis_tready is high only while the
// sequencer is idle. Every step goes through the entry store, which has one
// write port and one read port with registered read data. An insert moves
// each entry above the key up one place, from the top down, and then writes
// the new entry; a full table is left as it is. Floor steps up through the
// entries not above the key, exact through the entries below it, and read
// fetches the single entry at the position, or none past the end.
// After the result is handed on, the sequencer goes idle to take the next
// word. A finished result sits in the output register; the next input word
// is taken meanwhile, and its result waits in the sequencer while the
// receiver stalls. Reset empties the table at once; no clearing pass is
// needed.
module sorted_symbol_floor_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // key, tag, position, zero pad
    input  logic [ssft_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op
    input  logic [ssft_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // sym_address, sym_tag, offset
    output logic [ssft_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [ssft_pkg::STATUS_W-1:0]      m_axis_tuser
);
    import ssft_pkg::*;

    req_t  req;
    res_t  res;
    logic  res_valid;
    logic  res_ready;
    logic  out_valid_reg, out_valid_next;
    res_t  out_reg, out_next;

    assign req.op       = op_t'(s_axis_tuser);
    assign req.key      = s_axis_tdata[ADDR_W-1:0];
    assign req.tag      = s_axis_tdata[ADDR_W +: TAG_W];
    assign req.position = s_axis_tdata[ADDR_W + TAG_W +: POS_W];

    ssft_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = OUT_DATA_W'({out_reg.offset, out_reg.tag, out_reg.address});

endmodule

// File: tb/sorted_symbol_floor_table_checker.sv
module sorted_symbol_floor_table_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // key, tag, position, zero pad
    input  logic [ssft_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [ssft_pkg::OP_W-1:0]       s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // sym_address, sym_tag, offset
    input  logic [ssft_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status
    input  logic [ssft_pkg::STATUS_W-1:0]   m_axis_tuser,
    output int                              failures,
    output int                              outstanding,
    output int                              seen_ok,
    output int                              seen_miss,
    output int                              seen_full
);
    timeunit 1ns;
    timeprecision 1ps;

    import ssft_pkg::*;

    logic [ADDR_W-1:0] sym_addr [DEPTH];
    logic [TAG_W-1:0]  sym_tag  [DEPTH];
    int                sym_count = 0;
    res_t              awaited_results [$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
        seen_ok     = 0;
        seen_miss   = 0;
        seen_full   = 0;
    end

    // applies one word to the shadow table and returns the response it should give
    function automatic res_t symbol_response(op_t op, logic [ADDR_W-1:0] key,
                                             logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos);
        res_t             r;
        int               i;
        int               j;
        int               hit;
        logic [TAG_W-1:0] t;
        r.status  = ST_OK;
        r.address = key;
        r.tag     = '0;
        r.offset  = '0;
        t         = tag & TAG_MASK;
        case (op)
            OP_INSERT:
            begin
                if (sym_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // after every entry not above the key, so duplicates keep arrival order
                    i = 0;
                    while (i < sym_count && sym_addr[i] <= key)
                        i++;
                    for (j = sym_count; j > i; j--)
                    begin
                        sym_addr[j] = sym_addr[j-1];
                        sym_tag[j]  = sym_tag[j-1];
                    end
                    sym_addr[i] = key;
                    sym_tag[i]  = t;
                    sym_count++;
                    r.tag = t;
                end
            end
            OP_FLOOR:
            begin
                hit = -1;
                for (i = 0; i < sym_count && sym_addr[i] <= key; i++)
                    hit = i;
                if (hit < 0)
                begin
                    r.status = ST_MISS;
                end
                else
                begin
                    while (hit > 0 && sym_addr[hit-1] == sym_addr[hit])
                        hit--;
                    r.address = sym_addr[hit];
                    r.tag     = sym_tag[hit];
                    r.offset  = key - sym_addr[hit];
                end
            end
            OP_EXACT:
            begin
                i = 0;
                while (i < sym_count && sym_addr[i] < key)
                    i++;
                if (i < sym_count && sym_addr[i] == key)
                    r.tag = sym_tag[i];
                else
                    r.status = ST_MISS;
            end
            OP_READ:
            begin
                if (int'(pos) < sym_count)
                begin
                    r.address = sym_addr[pos];
                    r.tag     = sym_tag[pos];
                end
                else
                begin
                    r.status  = ST_MISS;
                    r.address = '0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string what, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    failures++;
                    $display("%0t ns: result word with none expected, got status %0d data %h",
                             $time, m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", ADDR_W'(want.status), ADDR_W'(m_axis_tuser));
                    check_field("sym_address", want.address, m_axis_tdata[31:0]);
                    check_field("sym_tag", ADDR_W'(want.tag), ADDR_W'(m_axis_tdata[47:32]));
                    check_field("offset", want.offset, m_axis_tdata[79:48]);
                    case (status_t'(m_axis_tuser))
                        ST_OK:   seen_ok++;
                        ST_MISS: seen_miss++;
                        ST_FULL: seen_full++;
                        default: ;
                    endcase
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                awaited_results.push_back(symbol_response(op_t'(s_axis_tuser),
                                                          s_axis_tdata[31:0],
                                                          s_axis_tdata[47:32],
                                                          s_axis_tdata[54:48]));
            outstanding = awaited_results.size();
        end
    end

endmodule

// File: tb/tb_sorted_symbol_floor_table.sv
module tb_sorted_symbol_floor_table;
    timeunit 1ns;
    timeprecision 1ps;

    import ssft_pkg::*;

    localparam int RANDOM_WORDS = 1875;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]       s_axis_tuser  = OP_INSERT;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    int failures;
    int outstanding;
    int seen_ok;
    int seen_miss;
    int seen_full;

    int          burst_left = 0;
    int          words_sent = 0;
    int          inserts_sent = 0;
    logic [31:0] known_keys [$];

    int rx_cycle   = 0;
    int stall_left = 0;

    always #10 clk = ~clk;

    sorted_symbol_floor_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sorted_symbol_floor_table_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .outstanding   (outstanding),
        .seen_ok       (seen_ok),
        .seen_miss     (seen_miss),
        .seen_full     (seen_full)
    );

    // receiver: cycles through always-ready, random, long-stall and alternating phases
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[10:9])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2:
            begin
                if (stall_left > 0)
                begin
                    stall_left    <= stall_left - 1;
                    m_axis_tready <= 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    stall_left    <= $urandom_range(1, 10);
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                end
            end
            default: m_axis_tready <= rx_cycle[0];
        endcase
    end

    task automatic send_word(input op_t op, input logic [31:0] key, input logic [15:0] tag,
                             input logic [6:0] pos);
        int gap;
        s_axis_tdata  <= {{(IN_DATA_W-55){1'b0}}, pos, tag, key};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
        if (op == OP_INSERT)
        begin
            if (inserts_sent < DEPTH)
                known_keys.push_back(key);
            inserts_sent++;
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        int          roll;
        int          sel;
        op_t         op;
        logic [31:0] key;
        logic [6:0]  pos;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then duplicates and both address extremes
        send_word(OP_FLOOR,  32'h0000_0000, 16'h0000, 7'd0);
        send_word(OP_EXACT,  32'hFFFF_FFFF, 16'hFFFF, 7'd127);
        send_word(OP_READ,   32'h0000_0000, 16'h0000, 7'd0);
        send_word(OP_INSERT, 32'h0000_1000, 16'hFFFF, 7'd0);
        send_word(OP_FLOOR,  32'h0000_0FFF, 16'h0000, 7'd0);
        send_word(OP_FLOOR,  32'h0000_1000, 16'h0000, 7'd0);
        send_word(OP_FLOOR,  32'hFFFF_FFFF, 16'h0000, 7'd0);
        send_word(OP_INSERT, 32'h0000_1000, 16'h0000, 7'd127);
        send_word(OP_INSERT, 32'h0000_1000, 16'h5A5A, 7'd0);
        send_word(OP_FLOOR,  32'h0000_1005, 16'h0000, 7'd0);
        send_word(OP_EXACT,  32'h0000_1000, 16'h0000, 7'd0);
        send_word(OP_INSERT, 32'h0000_0000, 16'h0001, 7'd0);
        send_word(OP_INSERT, 32'hFFFF_FFFF, 16'h8000, 7'd0);
        send_word(OP_FLOOR,  32'h0000_0000, 16'h0000, 7'd0);
        send_word(OP_FLOOR,  32'hFFFF_FFFE, 16'h0000, 7'd0);
        send_word(OP_FLOOR,  32'hFFFF_FFFF, 16'h0000, 7'd0);
        send_word(OP_EXACT,  32'h0000_1001, 16'h0000, 7'd0);
        send_word(OP_EXACT,  32'h0000_0000, 16'h0000, 7'd0);
        send_word(OP_READ,   32'h0000_0000, 16'h0000, 7'd0);
        send_word(OP_READ,   32'h0000_0000, 16'h0000, 7'd1);
        send_word(OP_READ,   32'h0000_0000, 16'h0000, 7'd4);
        send_word(OP_READ,   32'h0000_0000, 16'h0000, 7'd5);
        send_word(OP_READ,   32'h0000_0000, 16'h0000, 7'd64);
        send_word(OP_READ,   32'hFFFF_FFFF, 16'hFFFF, 7'd127);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            roll = $urandom_range(0, 99);
            sel  = $urandom_range(0, 9);
            if (roll < 12)
                op = OP_INSERT;
            else if (roll < 50)
                op = OP_FLOOR;
            else if (roll < 80)
                op = OP_EXACT;
            else
                op = OP_READ;

            if (op == OP_INSERT)
            begin
                if (sel < 3)
                    key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else if (sel == 3)
                    key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                else
                    key = $urandom;
            end
            else if (sel < 5)
                key = known_keys[$urandom_range(0, known_keys.size() - 1)]
                      + 32'($urandom_range(0, 6)) - 32'd3;
            else if (sel == 5)
                key = known_keys[$urandom_range(0, known_keys.size() - 1)] - 32'd1;
            else if (sel == 6)
                key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            else
                key = $urandom;

            if (op == OP_READ && $urandom_range(0, 7) != 0)
                pos = 7'($urandom_range(0, 66));
            else
                pos = 7'($urandom_range(0, 127));

            send_word(op, key, 16'($urandom), pos);
        end

        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (150) @(negedge clk);

        $display("covered %0d words (%0d inserts, table filled to %0d): %0d ok, %0d miss, %0d full",
                 words_sent, inserts_sent, (inserts_sent < DEPTH) ? inserts_sent : DEPTH,
                 seen_ok, seen_miss, seen_full);
        if (failures == 0)
            $display("sorted_symbol_floor_table test passed");
        else
            $display("sorted_symbol_floor_table test failed");
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("timeout with %0d words still awaited", outstanding);
        $display("sorted_symbol_floor_table test failed");
        $finish;
    end

endmodule
